[src/wrr_pkg.sv]
// Shared types and constants for the weighted round-robin task scheduler.
// Used by wrr_ctrl, wrr_dpath and nice_weighted_round_robin; no dependencies.
package wrr_pkg;

    typedef enum logic [1:0] {
        OP_YIELD     = 2'd0,
        OP_SET_STATE = 2'd1,
        OP_SET_NICE  = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_ABSENT   = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_WAITING  = 2'd3
    } run_state_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_PREV_RD,
        C_PREV_CHK,
        C_SCAN,
        C_SWAP,
        C_STATE_WR,
        C_NICE_RD,
        C_NICE_WR,
        C_RESULT
    } ctrl_state_t;

    typedef logic signed [5:0] nice_t;
    typedef logic [4:0]        skip_t;

    localparam logic signed [7:0] NICE_MAX = 8'sd19;
    localparam logic signed [7:0] NICE_MIN = -8'sd20;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input request
        logic rd_prev;   // read the running slot's entry
        logic prev_chk;  // latch whether the running slot is still running
        logic scan;      // evaluate one candidate slot
        logic swap;      // retire previous slot, switch running slot
        logic state_wr;  // set-state write
        logic nice_rd;   // read target slot for set-nice
        logic nice_wr;   // set-nice write
        logic out_load;  // load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done; // candidate chosen or ring exhausted
        logic pick;      // current candidate chosen
        logic out_free;  // result register can take a new result
    } sts_t;

endpackage

[src/wrr_ctrl.sv]
// Sequencer for the scheduler: walks each request through its read,
// scan and write steps. Depends on wrr_pkg.
module wrr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  wrr_pkg::op_t      in_op,
    input  wrr_pkg::sts_t     sts,
    output wrr_pkg::cmd_t     cmd
);

    wrr_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wrr_pkg::C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wrr_pkg::C_IDLE: begin
                if (s_tvalid) begin
                    case (in_op)
                        wrr_pkg::OP_YIELD:     state_next = wrr_pkg::C_PREV_RD;
                        wrr_pkg::OP_SET_STATE: state_next = wrr_pkg::C_STATE_WR;
                        wrr_pkg::OP_SET_NICE:  state_next = wrr_pkg::C_NICE_RD;
                        default:               state_next = wrr_pkg::C_RESULT;
                    endcase
                end
            end
            wrr_pkg::C_PREV_RD:  state_next = wrr_pkg::C_PREV_CHK;
            wrr_pkg::C_PREV_CHK: state_next = wrr_pkg::C_SCAN;
            wrr_pkg::C_SCAN: begin
                if (sts.scan_done) begin
                    state_next = sts.pick ? wrr_pkg::C_SWAP : wrr_pkg::C_RESULT;
                end
            end
            wrr_pkg::C_SWAP:     state_next = wrr_pkg::C_RESULT;
            wrr_pkg::C_STATE_WR: state_next = wrr_pkg::C_RESULT;
            wrr_pkg::C_NICE_RD:  state_next = wrr_pkg::C_NICE_WR;
            wrr_pkg::C_NICE_WR:  state_next = wrr_pkg::C_RESULT;
            wrr_pkg::C_RESULT: begin
                if (sts.out_free) begin
                    state_next = wrr_pkg::C_IDLE;
                end
            end
            default: state_next = wrr_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            wrr_pkg::C_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            wrr_pkg::C_PREV_RD:  cmd.rd_prev  = 1'b1;
            wrr_pkg::C_PREV_CHK: cmd.prev_chk = 1'b1;
            wrr_pkg::C_SCAN:     cmd.scan     = 1'b1;
            wrr_pkg::C_SWAP:     cmd.swap     = 1'b1;
            wrr_pkg::C_STATE_WR: cmd.state_wr = 1'b1;
            wrr_pkg::C_NICE_RD:  cmd.nice_rd  = 1'b1;
            wrr_pkg::C_NICE_WR:  cmd.nice_wr  = 1'b1;
            wrr_pkg::C_RESULT:   cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

endmodule

[src/wrr_dpath.sv]
// Datapath of the scheduler: slot table memories, scan pointer, running slot
// and result register. Driven by wrr_ctrl; depends on wrr_pkg.
module wrr_dpath #(
    parameter int SLOTS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  wrr_pkg::cmd_t     cmd,
    output wrr_pkg::sts_t     sts,
    input  logic [15:0]       s_tdata,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [7:0]        m_tdata
);

    localparam int SW = $clog2(SLOTS);

    function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] s);
        ring_next = (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    // captured request
    logic [3:0]              slot_reg;
    wrr_pkg::run_state_t     rs_reg;
    logic signed [7:0]       nice_reg;

    logic [SW-1:0]           running_reg;
    logic [SW-1:0]           cand_reg;
    logic [SW-1:0]           pick_reg;
    logic                    prev_run_reg;
    logic                    switched_reg;
    logic                    status_reg;
    logic                    m_tvalid_reg;
    logic [7:0]              m_tdata_reg;

    // slot table: one array per field, valid bits stand in for reset values
    logic [1:0]              st_mem   [SLOTS];
    wrr_pkg::nice_t          nice_mem [SLOTS];
    wrr_pkg::skip_t          skip_mem [SLOTS];
    logic [SLOTS-1:0]        st_vld_reg, nice_vld_reg, skip_vld_reg;

    logic [SW-1:0]           rd_addr;
    logic [SW-1:0]           rd_addr_reg;
    logic [1:0]              st_q_reg;
    wrr_pkg::nice_t          nice_q_reg;
    wrr_pkg::skip_t          skip_q_reg;
    logic                    st_qv_reg, nice_qv_reg, skip_qv_reg;

    wrr_pkg::run_state_t     st_rd;
    wrr_pkg::nice_t          nice_rd;
    wrr_pkg::skip_t          skip_rd;

    logic [SW-1:0]           slot_addr;
    logic                    in_range;
    logic                    nice_pos, ready, skip_it, pick_now, last;
    logic                    nice_ok;
    logic signed [7:0]       nice_clamp;

    logic                    st_we,   nice_we,   skip_we;
    logic [SW-1:0]           st_wa,   nice_wa,   skip_wa;
    logic [1:0]              st_wd;
    wrr_pkg::nice_t          nice_wd;
    wrr_pkg::skip_t          skip_wd;

    assign slot_addr = SW'(slot_reg);
    assign in_range  = 32'(slot_reg) < SLOTS;

    always_comb begin
        if (cmd.rd_prev) begin
            rd_addr = running_reg;
        end else if (cmd.prev_chk) begin
            rd_addr = cand_reg;
        end else if (cmd.scan) begin
            rd_addr = ring_next(cand_reg);
        end else begin
            rd_addr = slot_addr;
        end
    end

    // registered reads
    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr;
        st_q_reg    <= st_mem[rd_addr];
        nice_q_reg  <= nice_mem[rd_addr];
        skip_q_reg  <= skip_mem[rd_addr];
        st_qv_reg   <= st_vld_reg[rd_addr];
        nice_qv_reg <= nice_vld_reg[rd_addr];
        skip_qv_reg <= skip_vld_reg[rd_addr];
    end

    always_comb begin
        if (st_qv_reg) begin
            st_rd = wrr_pkg::run_state_t'(st_q_reg);
        end else begin
            st_rd = (rd_addr_reg == '0) ? wrr_pkg::ST_RUNNING : wrr_pkg::ST_ABSENT;
        end
        nice_rd = nice_qv_reg ? nice_q_reg : '0;
        skip_rd = skip_qv_reg ? skip_q_reg : '0;
    end

    assign nice_pos = !nice_rd[5] && (nice_rd != '0);
    assign ready    = (st_rd == wrr_pkg::ST_RUNNABLE) || (st_rd == wrr_pkg::ST_RUNNING);
    assign skip_it  = ready && nice_pos && (skip_rd != '0);
    assign pick_now = ready && !skip_it;
    assign last     = ring_next(cand_reg) == running_reg;
    assign nice_ok  = in_range && (st_rd != wrr_pkg::ST_ABSENT);

    always_comb begin
        if (nice_reg < wrr_pkg::NICE_MIN) begin
            nice_clamp = wrr_pkg::NICE_MIN;
        end else if (nice_reg > wrr_pkg::NICE_MAX) begin
            nice_clamp = wrr_pkg::NICE_MAX;
        end else begin
            nice_clamp = nice_reg;
        end
    end

    assign sts.scan_done = pick_now || last;
    assign sts.pick      = pick_now;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // write port selection
    always_comb begin
        st_we   = 1'b0;
        st_wa   = cand_reg;
        st_wd   = wrr_pkg::ST_RUNNING;
        nice_we = 1'b0;
        nice_wa = slot_addr;
        nice_wd = nice_clamp[5:0];
        skip_we = 1'b0;
        skip_wa = cand_reg;
        skip_wd = skip_rd - 1'b1;
        if (cmd.scan) begin
            st_we = pick_now;
            if (skip_it) begin
                skip_we = 1'b1;
            end else if (pick_now && nice_pos) begin
                skip_we = 1'b1;
                skip_wd = nice_rd[4:0];
            end
        end else if (cmd.swap) begin
            st_we = prev_run_reg;
            st_wa = running_reg;
            st_wd = wrr_pkg::ST_RUNNABLE;
        end else if (cmd.state_wr) begin
            st_we = in_range;
            st_wa = slot_addr;
            st_wd = rs_reg;
        end else if (cmd.nice_wr) begin
            nice_we = nice_ok;
            skip_we = nice_ok;
            skip_wa = slot_addr;
            skip_wd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_wa] <= st_wd;
        end
        if (nice_we) begin
            nice_mem[nice_wa] <= nice_wd;
        end
        if (skip_we) begin
            skip_mem[skip_wa] <= skip_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg   <= '0;
            nice_vld_reg <= '0;
            skip_vld_reg <= '0;
        end else begin
            if (st_we) begin
                st_vld_reg[st_wa] <= 1'b1;
            end
            if (nice_we) begin
                nice_vld_reg[nice_wa] <= 1'b1;
            end
            if (skip_we) begin
                skip_vld_reg[skip_wa] <= 1'b1;
            end
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            slot_reg <= s_tdata[5:2];
            rs_reg   <= wrr_pkg::run_state_t'(s_tdata[7:6]);
            nice_reg <= s_tdata[15:8];
        end
        if (cmd.rd_prev) begin
            cand_reg <= ring_next(running_reg);
        end else if (cmd.scan) begin
            cand_reg <= ring_next(cand_reg);
        end
        if (cmd.prev_chk) begin
            prev_run_reg <= (st_rd == wrr_pkg::ST_RUNNING);
        end
        if (cmd.scan && pick_now) begin
            pick_reg <= cand_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= '0;
            switched_reg <= 1'b0;
            status_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                switched_reg <= 1'b0;
                status_reg   <= 1'b0;
            end
            if (cmd.swap) begin
                running_reg  <= pick_reg;
                switched_reg <= 1'b1;
            end
            if (cmd.nice_wr) begin
                status_reg <= !nice_ok;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {2'b00, status_reg, switched_reg, 4'(running_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/nice_weighted_round_robin.sv]
// Weighted round-robin task scheduler with per-slot nice values.
// Top level: joins wrr_ctrl and wrr_dpath; depends on wrr_pkg.
//
// One request on the s_ channel gives one result on the m_ channel.
// Requests: yield (scan the other slots in index order after the running
// slot and switch to the first ready one whose skip count is spent), set
// slot state, and set slot nice (clamped to -20..19, skip count cleared).
// Results carry the running slot, a switch flag and a status bit that is
// set when set-nice targets an absent or out-of-range slot.
// Flow: one request at a time. A yield reads the running slot, checks it, then
// runs the scan loop, which reads one slot a cycle from the slot table, then the
// switch and result steps; set-nice reads then writes the slot, set-state writes it.
// The next request can be taken in the cycle after the result is loaded.
// s_tready is high only while no request is in progress. A result sits in
// an output register, so the next request is taken while it waits; if the
// receiver still stalls when that request finishes, the block holds there.
// Reset (aresetn low, synchronous): slot 0 running, all other slots absent,
// nice values and skip counts zero, no result pending. No clearing pass.
module nice_weighted_round_robin #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[1:0], slot[5:2], run_state[7:6], nice_value[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // selected_slot[3:0], switched[4], status[5], zero[7:6]
);

    wrr_pkg::cmd_t cmd;
    wrr_pkg::sts_t sts;

    wrr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (wrr_pkg::op_t'(s_tdata[1:0])),
        .sts      (sts),
        .cmd      (cmd)
    );

    wrr_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // one request in flight: accepting a request closes the input side
    a_single_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // a result only enters a free output register
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending result");

    // scan ends once a slot is picked or the ring is exhausted
    a_scan_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan && sts.scan_done) |=> !cmd.scan)
        else $error("scan continued past its end");

    // a switch is always followed by the result step
    a_swap_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap |=> !cmd.scan && !cmd.swap && !s_tready)
        else $error("switch not followed by result");

endmodule
